>>> rtl/repg_pkg.sv
// ============================================================================
// repg_pkg
// Shared types and constants of the RSA exponent pair generator.
// ============================================================================
package repg_pkg;

    // Width of one prime factor on the input item.
    localparam int PRIME_W = 16;
    // Width of the internal arithmetic words and of the wide result fields.
    localparam int WORD_W = 32;
    // Default for the top level's prime width parameter.
    localparam int PRIME_BITS_DEF = 16;

    typedef enum logic [1:0] {
        KEY_OK          = 2'd0,
        KEY_BAD_INPUT   = 2'd1,
        KEY_NO_EXPONENT = 2'd2
    } key_status_t;

    typedef struct packed {
        logic [PRIME_W-1:0] p_prime;
        logic [PRIME_W-1:0] q_prime;
    } key_in_t;

    typedef struct packed {
        logic [WORD_W-1:0] modulus_n;
        logic [WORD_W-1:0] public_exponent;
        logic [WORD_W-1:0] private_exponent;
        key_status_t       key_status;
    } key_out_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_N,
        ST_MUL_F,
        ST_CHECK,
        ST_EU_INIT,
        ST_EU_TEST,
        ST_EU_DIV,
        ST_EU_MUL,
        ST_FINISH
    } repg_state_t;

endpackage

>>> rtl/repg_serial_mult.sv
// ============================================================================
// repg_serial_mult
// Bit-serial shift-add multiplier; one multiplier bit per cycle, low word kept.
// ============================================================================
module repg_serial_mult
    import repg_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [WORD_W-1:0] a,
    input  logic [WORD_W-1:0] b,
    output logic              done,
    output logic [WORD_W-1:0] product
);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [WORD_W-1:0] a_reg, a_next;
    logic [WORD_W-1:0] b_reg, b_next;
    logic [WORD_W-1:0] acc_reg, acc_next;

    // The multiplier word shifts right and stops as soon as it runs out of ones.
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        a_next    = a_reg;
        b_next    = b_reg;
        acc_next  = acc_reg;
        if (start)
        begin
            busy_next = 1'b1;
            a_next    = a;
            b_next    = b;
            acc_next  = '0;
        end
        else if (busy_reg)
        begin
            if (b_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                if (b_reg[0])
                begin
                    acc_next = acc_reg + a_reg;
                end
                a_next = a_reg << 1;
                b_next = b_reg >> 1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        acc_reg <= acc_next;
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

>>> rtl/repg_serial_div.sv
// ============================================================================
// repg_serial_div
// Restoring divider; one quotient bit per cycle over the full word.
// ============================================================================
module repg_serial_div
    import repg_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [WORD_W-1:0] dividend,
    input  logic [WORD_W-1:0] divisor,
    output logic              done,
    output logic [WORD_W-1:0] quotient,
    output logic [WORD_W-1:0] remainder
);

    localparam int CNT_W = $clog2(WORD_W + 1);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [WORD_W-1:0] quo_reg, quo_next;
    logic [WORD_W-1:0] rem_reg, rem_next;
    logic [WORD_W-1:0] dsr_reg, dsr_next;
    logic [WORD_W:0]   shifted;
    logic [WORD_W:0]   diff;
    logic              borrow;

    // The dividend shifts out of the top of the quotient register while
    // quotient bits shift in at the bottom.
    assign shifted = {rem_reg, quo_reg[WORD_W-1]};
    assign diff    = shifted - {1'b0, dsr_reg};
    assign borrow  = (shifted < {1'b0, dsr_reg});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(WORD_W);
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - CNT_W'(1);
                quo_next = {quo_reg[WORD_W-2:0], ~borrow};
                rem_next = borrow ? shifted[WORD_W-1:0] : diff[WORD_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

>>> rtl/rsa_exponent_pair_generator_unit.sv
// ============================================================================
// rsa_exponent_pair_generator_unit
// RSA key pair from two primes: modulus, smallest public exponent, inverse.
// ============================================================================
// The block takes one item holding two primes p and q and returns one item
// with n = p*q, the smallest public exponent e >= 3 below n that is coprime
// to f = (p-1)*(q-1), and the private exponent d in [1, f-1] with
// d*e mod f = 1. Each prime is taken modulo 2^PRIME_BITS. If p < 2, q < 2 or
// f < 2 the status reads bad input and both exponents are 0; if no exponent
// exists below n the status reads no exponent found and both exponents are 0.
// Primality is not checked. One item is worked on at a time: n and f come
// from a bit-serial shift-add multiplier, n first and then f. Every
// candidate e then runs an extended Euclid loop on (f, e); each Euclid step
// divides in the restoring divider and then multiplies the quotient by the
// current coefficient in the multiplier. The loop ends at a remainder of 1,
// which gives d at once, or at a remainder of 0, which rejects the
// candidate. A finished result waits in an output register, and the next
// item is taken as soon as the engine is back in idle.
// ============================================================================
module rsa_exponent_pair_generator_unit
    import repg_pkg::*;
#(
    parameter int PRIME_BITS = PRIME_BITS_DEF
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  key_in_t  in_data,
    output logic     out_valid,
    input  logic     out_ready,
    output key_out_t out_data
);

    // Only the bits of the primes that survive the modulo are stored.
    localparam int IN_BITS = (PRIME_BITS < PRIME_W) ? PRIME_BITS : PRIME_W;

    repg_state_t state_reg, state_next;

    logic [IN_BITS-1:0] p_reg, p_next;
    logic [IN_BITS-1:0] q_reg, q_next;
    logic [WORD_W-1:0]  p_word, q_word;
    logic [WORD_W-1:0]  n_reg, n_next;
    logic [WORD_W-1:0]  f_reg, f_next;
    logic [WORD_W-1:0]  cand_reg, cand_next;
    logic [WORD_W-1:0]  r0_reg, r0_next;
    logic [WORD_W-1:0]  r1_reg, r1_next;
    logic [WORD_W-1:0]  u0_reg, u0_next;
    logic [WORD_W-1:0]  u1_reg, u1_next;
    logic [WORD_W-1:0]  quot_reg, quot_next;
    logic [WORD_W-1:0]  rem_reg, rem_next;
    logic               odd_reg, odd_next;
    logic [WORD_W-1:0]  e_reg, e_next;
    logic [WORD_W-1:0]  d_reg, d_next;
    key_status_t        status_reg, status_next;

    logic               out_valid_reg, out_valid_next;
    key_out_t           out_data_reg, out_data_next;

    logic               in_take;
    logic               out_load;
    logic               bad_input;

    logic               mul_start;
    logic [WORD_W-1:0]  mul_a, mul_b;
    logic               mul_done;
    logic [WORD_W-1:0]  mul_product;

    logic               div_start;
    logic               div_done;
    logic [WORD_W-1:0]  div_quotient, div_remainder;

    repg_serial_mult u_mult (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .product (mul_product)
    );

    // The divider always works on the current Euclid pair.
    repg_serial_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (r0_reg),
        .divisor   (r1_reg),
        .done      (div_done),
        .quotient  (div_quotient),
        .remainder (div_remainder)
    );

    assign in_ready = (state_reg == ST_IDLE);
    assign in_take  = in_valid && in_ready;
    assign out_load = (state_reg == ST_FINISH) && (!out_valid_reg || out_ready);

    assign p_word = {{(WORD_W - IN_BITS){1'b0}}, p_reg};
    assign q_word = {{(WORD_W - IN_BITS){1'b0}}, q_reg};

    // The totient is only trusted once both primes are known to be at least 2.
    assign bad_input = (p_word < WORD_W'(2)) || (q_word < WORD_W'(2)) ||
                       (f_reg < WORD_W'(2));

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    state_next = ST_MUL_N;
                end
            end
            ST_MUL_N:
            begin
                if (mul_done)
                begin
                    state_next = ST_MUL_F;
                end
            end
            ST_MUL_F:
            begin
                if (mul_done)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                state_next = bad_input ? ST_FINISH : ST_EU_INIT;
            end
            ST_EU_INIT:
            begin
                state_next = (cand_reg >= n_reg) ? ST_FINISH : ST_EU_TEST;
            end
            ST_EU_TEST:
            begin
                priority if (r1_reg == WORD_W'(1))
                begin
                    state_next = ST_FINISH;
                end
                else if (r1_reg == '0)
                begin
                    state_next = ST_EU_INIT;
                end
                else
                begin
                    state_next = ST_EU_DIV;
                end
            end
            ST_EU_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_EU_MUL;
                end
            end
            ST_EU_MUL:
            begin
                if (mul_done)
                begin
                    state_next = ST_EU_TEST;
                end
            end
            ST_FINISH:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath and unit control for each state.
    always_comb
    begin
        p_next         = p_reg;
        q_next         = q_reg;
        n_next         = n_reg;
        f_next         = f_reg;
        cand_next      = cand_reg;
        r0_next        = r0_reg;
        r1_next        = r1_reg;
        u0_next        = u0_reg;
        u1_next        = u1_reg;
        quot_next      = quot_reg;
        rem_next       = rem_reg;
        odd_next       = odd_reg;
        e_next         = e_reg;
        d_next         = d_reg;
        status_next    = status_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg;
        mul_start      = 1'b0;
        mul_a          = p_word;
        mul_b          = q_word;
        div_start      = 1'b0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                // The modulus multiply starts straight from the accepted item.
                if (in_take)
                begin
                    p_next    = in_data.p_prime[IN_BITS-1:0];
                    q_next    = in_data.q_prime[IN_BITS-1:0];
                    mul_start = 1'b1;
                    mul_a     = {{(WORD_W - IN_BITS){1'b0}},
                                 in_data.p_prime[IN_BITS-1:0]};
                    mul_b     = {{(WORD_W - IN_BITS){1'b0}},
                                 in_data.q_prime[IN_BITS-1:0]};
                end
            end
            ST_MUL_N:
            begin
                // Store the modulus, then start the totient, on the shared multiplier.
                if (mul_done)
                begin
                    n_next    = mul_product;
                    mul_start = 1'b1;
                    mul_a     = p_word - WORD_W'(1);
                    mul_b     = q_word - WORD_W'(1);
                end
            end
            ST_MUL_F:
            begin
                if (mul_done)
                begin
                    f_next = mul_product;
                end
            end
            ST_CHECK:
            begin
                e_next      = '0;
                d_next      = '0;
                cand_next   = WORD_W'(3);
                status_next = bad_input ? KEY_BAD_INPUT : KEY_OK;
            end
            ST_EU_INIT:
            begin
                if (cand_reg >= n_reg)
                begin
                    status_next = KEY_NO_EXPONENT;
                end
                else
                begin
                    // Euclid on (f, e) with the magnitudes of the e coefficients.
                    r0_next  = f_reg;
                    r1_next  = cand_reg;
                    u0_next  = '0;
                    u1_next  = WORD_W'(1);
                    odd_next = 1'b1;
                end
            end
            ST_EU_TEST:
            begin
                priority if (r1_reg == WORD_W'(1))
                begin
                    // The coefficient signs alternate; an even step is negative.
                    e_next = cand_reg;
                    d_next = odd_reg ? u1_reg : (f_reg - u1_reg);
                end
                else if (r1_reg == '0)
                begin
                    // A common factor remains: try the next candidate.
                    cand_next = cand_reg + WORD_W'(1);
                end
                else
                begin
                    div_start = 1'b1;
                end
            end
            ST_EU_DIV:
            begin
                if (div_done)
                begin
                    quot_next = div_quotient;
                    rem_next  = div_remainder;
                    mul_start = 1'b1;
                    mul_a     = u1_reg;
                    mul_b     = div_quotient;
                end
            end
            ST_EU_MUL:
            begin
                if (mul_done)
                begin
                    r0_next  = r1_reg;
                    r1_next  = rem_reg;
                    u0_next  = u1_reg;
                    u1_next  = u0_reg + mul_product;
                    odd_next = ~odd_reg;
                end
            end
            ST_FINISH:
            begin
                if (out_load)
                begin
                    out_valid_next                 = 1'b1;
                    out_data_next.modulus_n        = n_reg;
                    out_data_next.public_exponent  = e_reg;
                    out_data_next.private_exponent = d_reg;
                    out_data_next.key_status       = status_reg;
                end
            end
            default:
            begin
                mul_b = quot_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg        <= p_next;
        q_reg        <= q_next;
        n_reg        <= n_next;
        f_reg        <= f_next;
        cand_reg     <= cand_next;
        r0_reg       <= r0_next;
        r1_reg       <= r1_next;
        u0_reg       <= u0_next;
        u1_reg       <= u1_next;
        quot_reg     <= quot_next;
        rem_reg      <= rem_next;
        odd_reg      <= odd_next;
        e_reg        <= e_next;
        d_reg        <= d_next;
        status_reg   <= status_next;
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

>>> dv/rsa_exponent_pair_generator_unit_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// rsa_exponent_pair_generator_unit_tb
// Self-checking bench for the RSA exponent pair generator.
// ============================================================================
// A short table of hand-picked factor pairs covers zero and one factors, the
// degenerate totient, tiny keys and the top of the 16-bit range. A random
// stream of mostly prime factors follows. Each unpinned item is predicted by
// an independent model, and each result is compared field by field in order.
// Both sides insert random idle cycles, the receiver once holds off long
// enough to back the block up, and the sender once drains the block.
// ============================================================================
module rsa_exponent_pair_generator_unit_tb;

    import repg_pkg::*;

    // Number of random items after the directed table.
    localparam int RANDOM_ITEMS = 300;
    // Items at the end of the random part that run without any idling.
    localparam int CALM_ITEMS = 50;
    // Length of the one long receiver hold-off, in cycles. It is sized so
    // that the engine can finish one item, park it in the output register
    // and finish the next one as well.
    localparam int HOLD_OFF_CYCLES = 12000;
    // Results seen before the long hold-off starts.
    localparam int HOLD_OFF_AFTER = 30;
    // Settling time after the last result.
    localparam int DRAIN_CYCLES = 200;
    // Hard stop. This is far above the time that all items plus the long
    // hold-off can need.
    localparam int CYCLE_LIMIT = 20_000_000;

    // One row of the directed table. When pinned is set, the result is
    // typed in the row; otherwise the predictor supplies it.
    typedef struct packed {
        logic [PRIME_W-1:0] p_prime;
        logic [PRIME_W-1:0] q_prime;
        logic               pinned;
        logic [WORD_W-1:0]  modulus_n;
        logic [WORD_W-1:0]  public_exponent;
        logic [WORD_W-1:0]  private_exponent;
        key_status_t        key_status;
    } key_row_t;

    // What the monitor should expect for an item that is being offered.
    typedef struct packed {
        logic     pinned;
        key_out_t value;
    } key_plan_t;

    localparam int DIRECTED_ROWS = 21;
    localparam key_row_t DIRECTED_KEYS [DIRECTED_ROWS] = '{
        // Zero and one factors are rejected, n is still reported.
        '{16'd0,     16'd0,     1'b1, 32'd0,     32'd0, 32'd0,  KEY_BAD_INPUT},
        '{16'd1,     16'd1,     1'b1, 32'd1,     32'd0, 32'd0,  KEY_BAD_INPUT},
        '{16'd0,     16'd65535, 1'b1, 32'd0,     32'd0, 32'd0,  KEY_BAD_INPUT},
        '{16'd65535, 16'd1,     1'b1, 32'd65535, 32'd0, 32'd0,  KEY_BAD_INPUT},
        '{16'd0,     16'd2,     1'b1, 32'd0,     32'd0, 32'd0,  KEY_BAD_INPUT},
        '{16'd2,     16'd0,     1'b1, 32'd0,     32'd0, 32'd0,  KEY_BAD_INPUT},
        // p = q = 2 gives a totient of one, which is also bad input.
        '{16'd2,     16'd2,     1'b1, 32'd4,     32'd0, 32'd0,  KEY_BAD_INPUT},
        // Smallest keys, some with e above the totient, and small inverses.
        '{16'd2,     16'd3,     1'b1, 32'd6,     32'd3, 32'd1,  KEY_OK},
        '{16'd3,     16'd2,     1'b1, 32'd6,     32'd3, 32'd1,  KEY_OK},
        '{16'd3,     16'd5,     1'b1, 32'd15,    32'd3, 32'd3,  KEY_OK},
        '{16'd5,     16'd7,     1'b1, 32'd35,    32'd5, 32'd5,  KEY_OK},
        '{16'd7,     16'd11,    1'b1, 32'd77,    32'd7, 32'd43, KEY_OK},
        // The rest come from the predictor.
        '{16'd3,     16'd3,     1'b0, 32'd0,     32'd0, 32'd0,  KEY_OK},
        '{16'd11,    16'd13,    1'b0, 32'd0,     32'd0, 32'd0,  KEY_OK},
        '{16'd4,     16'd4,     1'b0, 32'd0,     32'd0, 32'd0,  KEY_OK},
        '{16'd65535, 16'd65535, 1'b0, 32'd0,     32'd0, 32'd0,  KEY_OK},
        '{16'd65521, 16'd65519, 1'b0, 32'd0,     32'd0, 32'd0,  KEY_OK},
        '{16'd65521, 16'd2,     1'b0, 32'd0,     32'd0, 32'd0,  KEY_OK},
        '{16'd2,     16'd65521, 1'b0, 32'd0,     32'd0, 32'd0,  KEY_OK},
        '{16'd43690, 16'd21845, 1'b0, 32'd0,     32'd0, 32'd0,  KEY_OK},
        '{16'd32768, 16'd32768, 1'b0, 32'd0,     32'd0, 32'd0,  KEY_OK}
    };

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     in_valid = 1'b0;
    logic     in_ready;
    key_in_t  in_data = '0;
    logic     out_valid;
    logic     out_ready = 1'b0;
    key_out_t out_data;

    key_plan_t key_plan [$];       // items offered, not yet accepted
    key_out_t  expected_keys [$];  // accepted items awaiting their result

    int  mismatch_count = 0;
    int  results_seen = 0;
    int  ok_keys = 0;
    int  rejected_keys = 0;
    int  cycle_count = 0;
    bit  calm_phase = 1'b0;

    rsa_exponent_pair_generator_unit uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------

    function automatic longint unsigned common_divisor(longint unsigned a,
                                                      longint unsigned b);
        longint unsigned r;
        while (b != 0)
        begin
            r = a % b;
            a = b;
            b = r;
        end
        return a;
    endfunction

    // Inverse of e modulo f by extended Euclid; the caller guarantees that
    // gcd(e, f) is one, so the result lies in [1, f-1].
    function automatic longint unsigned invert_modulo(longint unsigned e,
                                                     longint unsigned f);
        longint r_prev;
        longint r_cur;
        longint t_prev;
        longint t_cur;
        longint quot;
        longint tmp;
        r_prev = longint'(f);
        r_cur  = longint'(e % f);
        t_prev = 0;
        t_cur  = 1;
        while (r_cur != 0)
        begin
            quot   = r_prev / r_cur;
            tmp    = r_prev - quot * r_cur;
            r_prev = r_cur;
            r_cur  = tmp;
            tmp    = t_prev - quot * t_cur;
            t_prev = t_cur;
            t_cur  = tmp;
        end
        if (t_prev < 0)
        begin
            t_prev = t_prev + longint'(f);
        end
        return longint'(t_prev);
    endfunction

    // Full key pair for one item: modulus, smallest coprime exponent from 3,
    // its inverse, and the status code.
    function automatic key_out_t derive_key_pair(key_in_t req);
        longint unsigned p;
        longint unsigned q;
        longint unsigned n;
        longint unsigned f;
        longint unsigned e;
        longint unsigned d;
        key_out_t        res;
        p = 64'(req.p_prime);
        q = 64'(req.q_prime);
        n = p * q;
        res.modulus_n        = n[WORD_W-1:0];
        res.public_exponent  = '0;
        res.private_exponent = '0;
        res.key_status       = KEY_OK;
        if (p < 2 || q < 2 || (p - 1) * (q - 1) < 2)
        begin
            res.key_status = KEY_BAD_INPUT;
        end
        else
        begin
            f = (p - 1) * (q - 1);
            e = 3;
            while (e < n && common_divisor(e, f) != 1)
            begin
                e = e + 1;
            end
            if (e < n)
            begin
                d = invert_modulo(e, f);
                res.public_exponent  = e[WORD_W-1:0];
                res.private_exponent = d[WORD_W-1:0];
            end
            else
            begin
                res.key_status = KEY_NO_EXPONENT;
            end
        end
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Random factor selection
    // ------------------------------------------------------------------------

    function automatic bit is_prime(int unsigned v);
        int unsigned div;
        if (v < 2)
        begin
            return 1'b0;
        end
        for (div = 2; div * div <= v; div++)
        begin
            if (v % div == 0)
            begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    // Mostly primes, small and large, so that most keys are well formed. The
    // rest are arbitrary words, tiny values, values near the top and powers of
    // two, so that every bit of both factors toggles and bad input recurs.
    function automatic logic [PRIME_W-1:0] pick_prime_factor();
        int unsigned v;
        int unsigned sel;
        sel = $urandom_range(0, 9);
        if (sel <= 5)
        begin
            v = (sel <= 2) ? $urandom_range(2, 255) : $urandom_range(2, 65521);
            while (!is_prime(v))
            begin
                v = v + 1;
            end
        end
        else if (sel == 6)
        begin
            v = $urandom_range(0, 65535);
        end
        else if (sel == 7)
        begin
            v = $urandom_range(0, 16);
        end
        else if (sel == 8)
        begin
            v = $urandom_range(65500, 65535);
        end
        else
        begin
            v = 1 << $urandom_range(0, 15);
        end
        return v[PRIME_W-1:0];
    endfunction

    // ------------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------------

    // Offers one item, optionally after a short idle burst, and returns at
    // the edge where it was taken. Valid is left high so that back-to-back
    // items need no extra edge.
    task automatic offer_key(input key_in_t req, input logic pinned,
                             input key_out_t pinned_val, input bit may_idle);
        key_plan_t plan;
        int        gap;
        if (may_idle && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 3);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        plan.pinned = pinned;
        plan.value  = pinned_val;
        key_plan.push_back(plan);
        in_valid <= 1'b1;
        in_data  <= req;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
    endtask

    initial
    begin
        key_row_t row;
        key_in_t  req;
        key_out_t pinned_val;
        int       i;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table: pinned rows carry their own result.
        for (i = 0; i < DIRECTED_ROWS; i++)
        begin
            row = DIRECTED_KEYS[i];
            req.p_prime = row.p_prime;
            req.q_prime = row.q_prime;
            pinned_val.modulus_n        = row.modulus_n;
            pinned_val.public_exponent  = row.public_exponent;
            pinned_val.private_exponent = row.private_exponent;
            pinned_val.key_status       = row.key_status;
            offer_key(req, row.pinned, pinned_val, 1'b1);
        end

        // Random stream, checked against the predictor.
        for (i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == RANDOM_ITEMS / 2)
            begin
                // Let the block run completely empty before going on.
                in_valid <= 1'b0;
                @(posedge clk);
                while (key_plan.size() != 0 || expected_keys.size() != 0)
                begin
                    @(posedge clk);
                end
            end
            calm_phase = (i >= RANDOM_ITEMS - CALM_ITEMS);
            req.p_prime = pick_prime_factor();
            req.q_prime = pick_prime_factor();
            offer_key(req, 1'b0, '0, !calm_phase);
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (key_plan.size() != 0 || expected_keys.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Ran %0d key requests (%0d from the table, %0d random).",
                 DIRECTED_ROWS + RANDOM_ITEMS, DIRECTED_ROWS, RANDOM_ITEMS);
        $display("Results checked: %0d valid key pairs, %0d rejected inputs.",
                 ok_keys, rejected_keys);
        if (mismatch_count == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // ------------------------------------------------------------------------
    // Receiver
    // ------------------------------------------------------------------------

    // Ready toggles in short random bursts, except for one long hold-off
    // early in the random part. During that hold-off the engine finishes an
    // item, parks it, takes the next one and then has to stall its input.
    initial
    begin
        bit held;
        int gap;
        held = 1'b0;
        @(posedge clk);
        while (!rst_n)
        begin
            @(posedge clk);
        end
        forever
        begin
            if (!held && results_seen >= HOLD_OFF_AFTER)
            begin
                held = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end
            else if (!calm_phase && $urandom_range(0, 4) == 0)
            begin
                gap = $urandom_range(1, 3);
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: both handshakes are sampled here, on the same edge, so the
    // order of the processes within a time step does not matter.
    // ------------------------------------------------------------------------

    always @(posedge clk)
    begin
        key_plan_t plan;
        key_out_t  want;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                plan = key_plan.pop_front();
                want = plan.pinned ? plan.value : derive_key_pair(in_data);
                expected_keys.push_back(want);
            end
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (expected_keys.size() == 0)
                begin
                    $error("result with no item pending: n=%0d e=%0d d=%0d status=%0d",
                           out_data.modulus_n, out_data.public_exponent,
                           out_data.private_exponent, out_data.key_status);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_keys.pop_front();
                    if (want.key_status == KEY_OK)
                    begin
                        ok_keys++;
                    end
                    else
                    begin
                        rejected_keys++;
                    end
                    if (out_data.modulus_n !== want.modulus_n)
                    begin
                        $error("modulus_n: expected %0d, got %0d",
                               want.modulus_n, out_data.modulus_n);
                        mismatch_count++;
                    end
                    if (out_data.public_exponent !== want.public_exponent)
                    begin
                        $error("public_exponent: expected %0d, got %0d",
                               want.public_exponent, out_data.public_exponent);
                        mismatch_count++;
                    end
                    if (out_data.private_exponent !== want.private_exponent)
                    begin
                        $error("private_exponent: expected %0d, got %0d",
                               want.private_exponent, out_data.private_exponent);
                        mismatch_count++;
                    end
                    if (out_data.key_status !== want.key_status)
                    begin
                        $error("key_status: expected %0d, got %0d",
                               want.key_status, out_data.key_status);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    // Watchdog against a hung handshake.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles with %0d results pending.",
                     cycle_count, expected_keys.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

endmodule

>>> filelist.f
rtl/repg_pkg.sv
rtl/repg_serial_mult.sv
rtl/repg_serial_div.sv
rtl/rsa_exponent_pair_generator_unit.sv
dv/rsa_exponent_pair_generator_unit_tb.sv
